[sv/kod_pkg.sv]
package kod_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int SLOT_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int KEY_W       = 24;
	localparam int DATA_W      = 32;
	localparam int TYPE_W      = 3;
	localparam int COUNT_OUT_W = 5;

	localparam int IN_TDATA_W  = 64;
	localparam int IN_TUSER_W  = 3;
	localparam int OUT_TDATA_W = 48;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_READ   = 2'd2,
		OP_WRITE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_NOT_FOUND = 3'd1,
		STAT_DUPLICATE = 3'd2,
		STAT_FULL      = 3'd3,
		STAT_DENIED    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		TYPE_BOOL    = 3'd0,
		TYPE_INT8    = 3'd1,
		TYPE_UINT8   = 3'd2,
		TYPE_INT16   = 3'd3,
		TYPE_UINT16  = 3'd4,
		TYPE_INT32   = 3'd5,
		TYPE_UINT32  = 3'd6,
		TYPE_FLOAT32 = 3'd7
	} type_code_t;

	// rights: bit 0 read, bit 1 write
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [TYPE_W-1:0] type_code;
		logic [1:0]        rights;
		logic [DATA_W-1:0] data;
	} entry_t;

	typedef struct packed {
		logic              done;
		logic              hit;
		logic [SLOT_W-1:0] hit_slot;
		logic              free_found;
		logic [SLOT_W-1:0] free_slot;
		entry_t            entry;
	} find_t;

	typedef struct packed {
		logic              we;
		logic              set_valid;
		logic              clr_valid;
		logic [SLOT_W-1:0] slot;
		entry_t            entry;
	} upd_t;

	function automatic logic [DATA_W-1:0] type_mask(input logic [TYPE_W-1:0] code);
		logic [DATA_W-1:0] m;
		case (code) inside
			TYPE_BOOL, TYPE_INT8, TYPE_UINT8: m = 32'h0000_00FF;
			TYPE_INT16, TYPE_UINT16:          m = 32'h0000_FFFF;
			default:                          m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

endpackage

[sv/kod_slot_table.sv]
module kod_slot_table (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [kod_pkg::KEY_W-1:0] key,
	input  kod_pkg::upd_t         upd,
	output kod_pkg::find_t        find
);
	import kod_pkg::*;

	entry_t            mem [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] valid_q;

	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic [KEY_W-1:0]  key_q;

	entry_t            rd_s1;
	logic [SLOT_W-1:0] addr_s1;
	logic              rd_vld_s1;

	logic              hit_q;
	logic              free_q;
	logic              done_q;
	logic [SLOT_W-1:0] hit_slot_q;
	logic [SLOT_W-1:0] free_slot_q;
	entry_t            hit_entry_q;

	logic              is_hit;
	logic              is_free;

	assign is_hit  = rd_vld_s1 && valid_q[addr_s1] && (rd_s1.key == key_q);
	assign is_free = rd_vld_s1 && !valid_q[addr_s1] && !free_q;

	// one write port, one read port, read data registered
	always_ff @(posedge clk) begin
		if (upd.we) begin
			mem[upd.slot] <= upd.entry;
		end
		rd_s1 <= mem[cnt_q[SLOT_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (upd.set_valid) begin
				valid_q[upd.slot] <= 1'b1;
			end
			if (upd.clr_valid) begin
				valid_q[upd.slot] <= 1'b0;
			end
		end
	end

	// scan sequencer: one slot read per cycle, compare in the cycle after the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= busy_q;
			done_q    <= rd_vld_s1 && (addr_s1 == SLOT_W'(MAX_ENTRIES - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else begin
				if (busy_q) begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(MAX_ENTRIES - 1)) begin
						busy_q <= 1'b0;
					end
				end
				if (is_hit) begin
					hit_q <= 1'b1;
				end
				if (is_free) begin
					free_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= cnt_q[SLOT_W-1:0];
		if (start) begin
			key_q <= key;
		end
		if (is_hit) begin
			hit_slot_q  <= addr_s1;
			hit_entry_q <= rd_s1;
		end
		if (is_free) begin
			free_slot_q <= addr_s1;
		end
	end

	assign find.done       = done_q;
	assign find.hit        = hit_q;
	assign find.hit_slot   = hit_slot_q;
	assign find.free_found = free_q;
	assign find.free_slot  = free_slot_q;
	assign find.entry      = hit_entry_q;

endmodule

[sv/keyed_object_dictionary_unit.sv]
// Keyed object dictionary: a table of up to 16 entries addressed by a 16-bit index and an
// 8-bit subindex, each holding a type, read/write rights and a value of up to 32 bits. One
// item in gives one result item out. Every item scans all slots of the slot memory, one
// read per cycle, then applies the operation in one read-modify-write step: the slot table
// reads and compares all 16 slots and hands the outcome to the control, which then applies
// the operation and registers the result. One item is handled at a time; the input is
// ready again in the same cycle as the result appears, so no new item is taken before the
// last one has been applied. A finished result sits in the output register while the next
// item is taken in; the apply step of that next item waits until the result before it has
// been taken.
module keyed_object_dictionary_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// key_index[15:0], key_subindex[23:16], type_code[26:24], may_read[27],
	// may_write[28], new_value[60:29], zero fill
	input  logic [kod_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// operation[1:0], has_value[2]
	input  logic [kod_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// success[0], status[3:1], read_value[35:4], entry_count[40:36], zero fill
	output logic [kod_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
	import kod_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SEARCH = 3'b010,
		S_EXEC   = 3'b100
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;

	op_t               op_q;
	logic [KEY_W-1:0]  key_q;
	logic [TYPE_W-1:0] type_q;
	logic              rd_q;
	logic              wr_q;
	logic [DATA_W-1:0] val_q;
	logic              has_q;

	logic              out_valid_q;
	logic              out_success_q;
	status_t           out_status_q;
	logic [DATA_W-1:0] out_read_value_q;
	logic [COUNT_OUT_W-1:0] out_count_q;

	find_t             find;
	upd_t              upd;
	logic              in_fire;
	logic              exec_go;
	logic [KEY_W-1:0]  in_key;

	status_t           status;
	logic [DATA_W-1:0] rval;
	logic [CNT_W-1:0]  count_nxt;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign in_key        = {s_axis_tdata[15:0], s_axis_tdata[23:16]};
	assign exec_go       = (state_q == S_EXEC) && (!out_valid_q || m_axis_tready);

	kod_slot_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_fire),
		.key    (in_key),
		.upd    (upd),
		.find   (find)
	);

	// apply the operation to the found or free slot
	always_comb begin
		status    = STAT_OK;
		rval      = '0;
		count_nxt = count_q;
		upd       = '0;
		upd.slot  = find.hit_slot;
		upd.entry = find.entry;
		if (op_q == OP_ADD) begin
			if (find.hit) begin
				status = STAT_DUPLICATE;
			end else if (!find.free_found) begin
				status = STAT_FULL;
			end else begin
				upd.we              = exec_go;
				upd.set_valid       = exec_go;
				upd.slot            = find.free_slot;
				upd.entry.key       = key_q;
				upd.entry.type_code = type_q;
				upd.entry.rights    = {wr_q, rd_q};
				upd.entry.data      = has_q ? (val_q & type_mask(type_q)) : '0;
				count_nxt           = count_q + CNT_W'(1);
			end
		end else if (!find.hit) begin
			status = STAT_NOT_FOUND;
		end else begin
			case (op_q)
				OP_REMOVE: begin
					upd.clr_valid = exec_go;
					count_nxt     = count_q - CNT_W'(1);
				end
				OP_READ: begin
					if (find.entry.rights[0]) begin
						rval = find.entry.data & type_mask(find.entry.type_code);
					end else begin
						status = STAT_DENIED;
					end
				end
				default: begin
					if (find.entry.rights[1] && has_q) begin
						upd.we         = exec_go;
						upd.entry.data = val_q & type_mask(find.entry.type_code);
					end else begin
						status = STAT_DENIED;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (exec_go) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (find.done) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_go) begin
						state_q <= S_IDLE;
						count_q <= count_nxt;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q   <= op_t'(s_axis_tuser[1:0]);
			has_q  <= s_axis_tuser[2];
			key_q  <= in_key;
			type_q <= s_axis_tdata[26:24];
			rd_q   <= s_axis_tdata[27];
			wr_q   <= s_axis_tdata[28];
			val_q  <= s_axis_tdata[60:29];
		end
		if (exec_go) begin
			out_success_q    <= (status == STAT_OK);
			out_status_q     <= status;
			out_read_value_q <= rval;
			out_count_q      <= COUNT_OUT_W'(count_nxt);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_count_q, out_read_value_q, out_status_q, out_success_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count above table size");

	a_success_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_success_q == (out_status_q == STAT_OK)))
		else $error("success flag disagrees with status");

	a_fail_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_success_q) |-> (out_read_value_q == '0))
		else $error("failed item carries a read value");

	a_done_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		find.done |-> (state_q == S_SEARCH))
		else $error("scan finished outside search");

	a_one_slot_change: assert property (@(posedge clk) disable iff (!arst_n)
		(upd.we || upd.set_valid || upd.clr_valid) |-> exec_go)
		else $error("slot table changed outside execute step");

endmodule

[dv/keyed_object_dictionary_unit_tb.sv]
`timescale 1ns / 100ps

module keyed_object_dictionary_unit_tb;
	import kod_pkg::*;

	typedef struct {
		op_t        op;
		logic [15:0] idx;
		logic [7:0]  sub;
		type_code_t tcode;
		logic        rd;
		logic        wr;
		logic [31:0] value;
		logic        has;
	} dict_cmd_t;

	typedef struct {
		logic        success;
		logic [2:0]  status;
		logic [31:0] rvalue;
		logic [4:0]  count;
	} dict_reply_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	// key_index, key_subindex, type_code, may_read, may_write, new_value, zero fill
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	// operation, has_value
	logic [IN_TUSER_W-1:0]  s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	// success, status, read_value, entry_count, zero fill
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// shadow copy of the dictionary
	bit          tbl_valid [MAX_ENTRIES];
	logic [23:0] tbl_key   [MAX_ENTRIES];
	type_code_t  tbl_type  [MAX_ENTRIES];
	logic [1:0]  tbl_rights[MAX_ENTRIES];
	logic [31:0] tbl_data  [MAX_ENTRIES];
	int unsigned tbl_count = 0;

	dict_reply_t pending_replies[$];
	int unsigned err_count = 0;
	int unsigned result_count = 0;
	int unsigned burst_left = 0;

	keyed_object_dictionary_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [31:0] width_mask(input type_code_t tc);
		case (tc)
			TYPE_BOOL, TYPE_INT8, TYPE_UINT8: return 32'h0000_00FF;
			TYPE_INT16, TYPE_UINT16:          return 32'h0000_FFFF;
			default:                          return 32'hFFFF_FFFF;
		endcase
	endfunction

	// applies one operation to the shadow table and returns the reply it gives
	function automatic dict_reply_t apply_dict_op(input dict_cmd_t c);
		dict_reply_t r;
		logic [23:0] key;
		int          hit;
		int          free;
		key      = {c.idx, c.sub};
		r.status = STAT_OK;
		r.rvalue = '0;
		hit      = -1;
		free     = -1;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (tbl_valid[i] && tbl_key[i] == key && hit < 0)
				hit = i;
			if (!tbl_valid[i] && free < 0)
				free = i;
		end
		if (c.op == OP_ADD) begin
			if (hit >= 0)
				r.status = STAT_DUPLICATE;
			else if (free < 0)
				r.status = STAT_FULL;
			else begin
				tbl_valid[free]  = 1'b1;
				tbl_key[free]    = key;
				tbl_type[free]   = c.tcode;
				tbl_rights[free] = {c.wr, c.rd};
				tbl_data[free]   = c.has ? (c.value & width_mask(c.tcode)) : 32'd0;
				tbl_count++;
			end
		end else if (hit < 0) begin
			r.status = STAT_NOT_FOUND;
		end else if (c.op == OP_REMOVE) begin
			tbl_valid[hit] = 1'b0;
			tbl_count--;
		end else if (c.op == OP_READ) begin
			if (tbl_rights[hit][0])
				r.rvalue = tbl_data[hit] & width_mask(tbl_type[hit]);
			else
				r.status = STAT_DENIED;
		end else begin
			if (tbl_rights[hit][1] && c.has)
				tbl_data[hit] = c.value & width_mask(tbl_type[hit]);
			else
				r.status = STAT_DENIED;
		end
		r.success = (r.status == STAT_OK);
		r.count   = tbl_count[4:0];
		return r;
	endfunction

	function automatic dict_cmd_t mk_cmd(input op_t op, input logic [15:0] idx,
			input logic [7:0] sub, input type_code_t tc, input logic rd, input logic wr,
			input logic [31:0] value, input logic has);
		dict_cmd_t c;
		c.op    = op;
		c.idx   = idx;
		c.sub   = sub;
		c.tcode = tc;
		c.rd    = rd;
		c.wr    = wr;
		c.value = value;
		c.has   = has;
		return c;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		err_count++;
	endtask

	// sends one item; the sender may idle between bursts of random length
	task automatic send_item(input dict_cmd_t c);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 8);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {3'b000, c.value, c.wr, c.rd, c.tcode, c.sub, c.idx};
		s_axis_tuser  <= {c.has, c.op};
		do
			@(posedge clk);
		while (!s_axis_tready);
		pending_replies.push_back(apply_dict_op(c));
	endtask

	// holds the sender off until every pending reply is back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		burst_left = 0;
	endtask

	always @(posedge clk) begin : check_results
		dict_reply_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_replies.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing pending",
					result_count));
			end else begin
				want = pending_replies.pop_front();
				if (m_axis_tdata[0] !== want.success)
					report_mismatch($sformatf("result %0d: success %b, want %b",
						result_count, m_axis_tdata[0], want.success));
				if (m_axis_tdata[3:1] !== want.status)
					report_mismatch($sformatf("result %0d: status %0d, want %0d",
						result_count, m_axis_tdata[3:1], want.status));
				if (m_axis_tdata[35:4] !== want.rvalue)
					report_mismatch($sformatf("result %0d: read_value %h, want %h",
						result_count, m_axis_tdata[35:4], want.rvalue));
				if (m_axis_tdata[40:36] !== want.count)
					report_mismatch($sformatf("result %0d: entry_count %0d, want %0d",
						result_count, m_axis_tdata[40:36], want.count));
			end
			result_count++;
		end
	end

	// receiver stalls in modes: always ready, coin flip, sparse, mostly ready
	initial begin : rx_stall
		int unsigned mode;
		int unsigned len;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			len  = $urandom_range(20, 300);
			repeat (len) begin
				@(posedge clk);
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= ($urandom_range(0, 1) == 1);
					2: m_axis_tready <= ($urandom_range(0, 7) == 0);
					default: m_axis_tready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	task automatic test_empty_table();
		send_item(mk_cmd(OP_READ,   16'h0000, 8'h00, TYPE_BOOL, 1'b0, 1'b0, 32'h0, 1'b0));
		send_item(mk_cmd(OP_WRITE,  16'h0000, 8'h00, TYPE_BOOL, 1'b0, 1'b0, 32'h1, 1'b1));
		send_item(mk_cmd(OP_REMOVE, 16'h0000, 8'h00, TYPE_BOOL, 1'b0, 1'b0, 32'h0, 1'b0));
	endtask

	// one entry per type, all loaded with all ones to see the width masking
	task automatic test_add_each_type();
		logic [15:0] idx;
		logic [7:0]  sub;
		for (int t = 0; t < 8; t++) begin
			idx = (t == 0) ? 16'hFFFF : 16'h1000 + 16'(t);
			sub = (t == 0) ? 8'hFF : 8'(t);
			send_item(mk_cmd(OP_ADD, idx, sub, type_code_t'(t), !t[0], t[1],
				32'hFFFF_FFFF, 1'b1));
		end
		send_item(mk_cmd(OP_READ, 16'hFFFF, 8'hFF, TYPE_BOOL, 1'b0, 1'b0, 32'h0, 1'b0));
		send_item(mk_cmd(OP_READ, 16'h1006, 8'h06, TYPE_BOOL, 1'b0, 1'b0, 32'h0, 1'b0));
	endtask

	task automatic test_add_cases();
		// add without a value stores zero
		send_item(mk_cmd(OP_ADD, 16'h2000, 8'h10, TYPE_UINT32, 1'b1, 1'b1,
			32'hDEAD_BEEF, 1'b0));
		send_item(mk_cmd(OP_READ, 16'h2000, 8'h10, TYPE_BOOL, 1'b0, 1'b0, 32'h0, 1'b0));
		send_item(mk_cmd(OP_ADD, 16'hFFFF, 8'hFF, TYPE_INT32, 1'b1, 1'b1, 32'h5, 1'b1));
	endtask

	task automatic test_access_rights();
		send_item(mk_cmd(OP_WRITE, 16'h1002, 8'h02, TYPE_BOOL, 1'b0, 1'b0,
			32'h1234_5678, 1'b1));
		send_item(mk_cmd(OP_READ,  16'h1002, 8'h02, TYPE_BOOL, 1'b0, 1'b0, 32'h0, 1'b0));
		send_item(mk_cmd(OP_WRITE, 16'h1001, 8'h01, TYPE_BOOL, 1'b0, 1'b0, 32'h55, 1'b1));
		send_item(mk_cmd(OP_WRITE, 16'h1006, 8'h06, TYPE_BOOL, 1'b0, 1'b0, 32'h77, 1'b0));
		send_item(mk_cmd(OP_READ,  16'h1001, 8'h01, TYPE_BOOL, 1'b0, 1'b0, 32'h0, 1'b0));
	endtask

	task automatic test_full_table();
		for (int i = 0; i < 7; i++)
			send_item(mk_cmd(OP_ADD, (i == 0) ? 16'h0000 : 16'h3000 + 16'(i),
				(i == 0) ? 8'h00 : 8'h80 | 8'(i), TYPE_INT16, 1'b1, 1'b1,
				32'hA5A5_0000 + i, 1'b1));
		send_item(mk_cmd(OP_ADD, 16'h5555, 8'h55, TYPE_UINT8, 1'b1, 1'b1, 32'h1, 1'b1));
		// duplicate is reported ahead of full
		send_item(mk_cmd(OP_ADD, 16'h1006, 8'h06, TYPE_UINT8, 1'b1, 1'b1, 32'h1, 1'b1));
		send_item(mk_cmd(OP_REMOVE, 16'h1004, 8'h04, TYPE_BOOL, 1'b0, 1'b0, 32'h0, 1'b0));
		send_item(mk_cmd(OP_ADD, 16'hAAAA, 8'hAA, TYPE_FLOAT32, 1'b1, 1'b0,
			32'h3F80_0000, 1'b1));
	endtask

	task automatic test_random_traffic(input int unsigned n_items);
		logic [23:0] key_pool[24];
		logic [23:0] leftover[$];
		logic [23:0] key;
		dict_cmd_t   c;
		int unsigned sent;
		int unsigned round_len;
		int unsigned bias;
		int unsigned roll;
		int unsigned add_lim;
		int unsigned rem_lim;
		int unsigned rd_lim;
		// start from an empty table so the pool keys control the fill level
		for (int i = 0; i < MAX_ENTRIES; i++)
			if (tbl_valid[i])
				leftover.push_back(tbl_key[i]);
		foreach (leftover[i])
			send_item(mk_cmd(OP_REMOVE, leftover[i][23:8], leftover[i][7:0], TYPE_BOOL,
				1'b0, 1'b0, 32'h0, 1'b0));
		key_pool[0] = 24'h000000;
		key_pool[1] = 24'hFFFFFF;
		for (int i = 2; i < 24; i++)
			key_pool[i] = 24'($urandom_range(0, 24'hFFFFFF));
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 2) == 0)
				wait_drained();
			round_len = $urandom_range(40, 120);
			bias = $urandom_range(0, 2);
			case (bias)
				0: begin add_lim = 50; rem_lim = 60; rd_lim = 80; end
				1: begin add_lim = 10; rem_lim = 55; rd_lim = 80; end
				default: begin add_lim = 25; rem_lim = 50; rd_lim = 75; end
			endcase
			repeat (round_len) begin
				roll = $urandom_range(0, 99);
				if (roll < add_lim)
					c.op = OP_ADD;
				else if (roll < rem_lim)
					c.op = OP_REMOVE;
				else if (roll < rd_lim)
					c.op = OP_READ;
				else
					c.op = OP_WRITE;
				// stray keys only for lookups so they never clog the table
				if (c.op != OP_ADD && $urandom_range(0, 9) == 0)
					key = 24'($urandom_range(0, 24'hFFFFFF));
				else
					key = key_pool[$urandom_range(0, 23)];
				c.idx   = key[23:8];
				c.sub   = key[7:0];
				c.tcode = type_code_t'($urandom_range(0, 7));
				c.rd    = ($urandom_range(0, 3) != 0);
				c.wr    = ($urandom_range(0, 3) != 0);
				c.value = $urandom();
				c.has   = ($urandom_range(0, 6) != 0);
				send_item(c);
				sent++;
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_add_each_type();
		test_add_cases();
		wait_drained();
		test_access_rights();
		test_full_table();
		wait_drained();
		test_random_traffic(1370);
		wait_drained();
		repeat (40) @(posedge clk);

		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
